>>> hdl/im2col_pkg.sv
// Shared types, codes and constants for the im2col patch gather block.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package im2col_pkg;

    // Default largest kernel height or width
    localparam int MAX_KERNEL_DEF = 7;

    // Bytes cleared by the zero tail command
    localparam logic [15:0] TAIL_BYTES = 16'd32;

    // Signed width of an input coordinate: output coordinate times stride, minus padding,
    // plus the dilated kernel offset
    localparam int COORD_W = 26;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        CFG_KERNEL_SHAPE = 3'd0,
        CFG_WINDOW_STEP  = 3'd1,
        CFG_PAD_OFFSETS  = 3'd2,
        CFG_INPUT_EXTENT = 3'd3,
        CFG_PIXEL_BYTES  = 3'd4,
        CFG_ROW_BYTES    = 3'd5,
        CFG_COPY_BYTES   = 3'd6,
        CFG_PAD_BYTE     = 3'd7
    } cfg_index_t;

    // Command kinds
    localparam logic [1:0] KIND_COPY = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_TAIL = 2'd2;

    // One output pixel request
    typedef struct packed {
        logic [31:0] source_base;
        logic [31:0] patch_base;
        logic [15:0] output_row;
        logic [15:0] output_col;
        logic [15:0] channel_offset;
    } request_t;

    // One copy command
    typedef struct packed {
        logic [1:0]         command_kind;
        logic [31:0]        read_address;
        logic [31:0]        write_address;
        logic [15:0]        byte_count;
        logic signed [7:0]  fill_value;
        logic               last;
    } result_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_V,
        ST_MUL_H,
        ST_MUL_ROW_ADDR,
        ST_MUL_COL_ADDR,
        ST_MUL_ROW_STEP,
        ST_MUL_COL_STEP,
        ST_TAP,
        ST_TAIL
    } state_t;

    // Shared multiplier operand selection
    typedef enum logic [2:0] {
        MUL_V,
        MUL_H,
        MUL_ROW_ADDR,
        MUL_COL_ADDR,
        MUL_ROW_STEP,
        MUL_COL_STEP
    } mul_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     tap;
        logic     tail;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic kernel_empty;
        logic row_end;
        logic last_row;
    } dp_status_t;

endpackage

>>> hdl/im2col_ctrl.sv
// Controller state machine of the im2col patch gather: setup steps, tap walk, tail.
// Depends on im2col_pkg.
module im2col_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  im2col_pkg::dp_status_t  status,
    output im2col_pkg::ctrl_cmd_t   cmd,
    output logic                    busy
);

    im2col_pkg::state_t state_reg;
    im2col_pkg::state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= im2col_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through setup multiplies, then one tap per cycle (none for an empty kernel), then the tail
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            im2col_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = im2col_pkg::ST_MUL_V;
                end
            end
            im2col_pkg::ST_MUL_V:        state_next = im2col_pkg::ST_MUL_H;
            im2col_pkg::ST_MUL_H:        state_next = im2col_pkg::ST_MUL_ROW_ADDR;
            im2col_pkg::ST_MUL_ROW_ADDR: state_next = im2col_pkg::ST_MUL_COL_ADDR;
            im2col_pkg::ST_MUL_COL_ADDR: state_next = im2col_pkg::ST_MUL_ROW_STEP;
            im2col_pkg::ST_MUL_ROW_STEP: state_next = im2col_pkg::ST_MUL_COL_STEP;
            im2col_pkg::ST_MUL_COL_STEP:
            begin
                if (status.kernel_empty)
                begin
                    state_next = im2col_pkg::ST_TAIL;
                end
                else
                begin
                    state_next = im2col_pkg::ST_TAP;
                end
            end
            im2col_pkg::ST_TAP:
            begin
                if (status.row_end && status.last_row)
                begin
                    state_next = im2col_pkg::ST_TAIL;
                end
            end
            im2col_pkg::ST_TAIL:         state_next = im2col_pkg::ST_IDLE;
            default:                     state_next = im2col_pkg::ST_IDLE;
        endcase
    end

    // Drive datapath commands from the state
    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = im2col_pkg::MUL_V;
        busy        = 1'b1;
        case (state_reg)
            im2col_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            im2col_pkg::ST_MUL_V:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = im2col_pkg::MUL_V;
            end
            im2col_pkg::ST_MUL_H:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = im2col_pkg::MUL_H;
            end
            im2col_pkg::ST_MUL_ROW_ADDR:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = im2col_pkg::MUL_ROW_ADDR;
            end
            im2col_pkg::ST_MUL_COL_ADDR:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = im2col_pkg::MUL_COL_ADDR;
            end
            im2col_pkg::ST_MUL_ROW_STEP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = im2col_pkg::MUL_ROW_STEP;
            end
            im2col_pkg::ST_MUL_COL_STEP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = im2col_pkg::MUL_COL_STEP;
            end
            im2col_pkg::ST_TAP:
            begin
                cmd.tap = 1'b1;
            end
            im2col_pkg::ST_TAIL:
            begin
                cmd.tail = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

>>> hdl/im2col_dp.sv
// Datapath of the im2col patch gather: configuration registers, shared multiplier,
// coordinate and address walkers, and the registered result. Depends on im2col_pkg.
module im2col_dp
#(
    parameter int MAX_KERNEL = im2col_pkg::MAX_KERNEL_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [31:0]             cfg_data,
    input  im2col_pkg::request_t    request,
    input  im2col_pkg::ctrl_cmd_t   cmd,
    output im2col_pkg::dp_status_t  status,
    output im2col_pkg::result_t     result,
    output logic                    result_strobe
);

    localparam int KW_W = $clog2(MAX_KERNEL + 1);
    localparam int CW   = im2col_pkg::COORD_W;

    // Configuration registers
    logic [15:0] kernel_shape_reg;
    logic [31:0] window_step_reg;
    logic [15:0] pad_offsets_reg;
    logic [31:0] input_extent_reg;
    logic [15:0] pixel_bytes_reg;
    logic [23:0] row_bytes_reg;
    logic [15:0] copy_bytes_reg;
    logic [7:0]  pad_byte_reg;

    // Request and walk state
    im2col_pkg::request_t   req_reg;
    logic signed [CW-1:0]   v_reg;
    logic signed [CW-1:0]   h_reg;
    logic signed [CW-1:0]   h0_reg;
    logic [31:0]            row_addr_reg;
    logic [31:0]            col_addr_reg;
    logic [31:0]            col_base_reg;
    logic [31:0]            row_step_reg;
    logic [31:0]            col_step_reg;
    logic [31:0]            wr_addr_reg;
    logic [KW_W-1:0]        i_reg;
    logic [KW_W-1:0]        j_reg;

    // Output stage
    im2col_pkg::result_t    result_reg;
    im2col_pkg::result_t    result_next;
    logic                   strobe_reg;

    logic [KW_W-1:0]        kh_eff;
    logic [KW_W-1:0]        kw_eff;
    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [31:0]            mul_p;
    logic                   row_end;
    logic                   outside;
    logic                   v_out;
    logic                   h_out;
    logic signed [CW-1:0]   dv_s;
    logic signed [CW-1:0]   dh_s;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_shape_reg <= 16'h0101;
            window_step_reg  <= 32'h0101_0101;
            pad_offsets_reg  <= 16'h0000;
            input_extent_reg <= 32'h0001_0001;
            pixel_bytes_reg  <= 16'd1;
            row_bytes_reg    <= 24'd1;
            copy_bytes_reg   <= 16'd1;
            pad_byte_reg     <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (im2col_pkg::cfg_index_t'(cfg_index))
                im2col_pkg::CFG_KERNEL_SHAPE: kernel_shape_reg <= cfg_data[15:0];
                im2col_pkg::CFG_WINDOW_STEP:  window_step_reg  <= cfg_data;
                im2col_pkg::CFG_PAD_OFFSETS:  pad_offsets_reg  <= cfg_data[15:0];
                im2col_pkg::CFG_INPUT_EXTENT: input_extent_reg <= cfg_data;
                im2col_pkg::CFG_PIXEL_BYTES:  pixel_bytes_reg  <= cfg_data[15:0];
                im2col_pkg::CFG_ROW_BYTES:    row_bytes_reg    <= cfg_data[23:0];
                im2col_pkg::CFG_COPY_BYTES:   copy_bytes_reg   <= cfg_data[15:0];
                im2col_pkg::CFG_PAD_BYTE:     pad_byte_reg     <= cfg_data[7:0];
                default:                      pad_byte_reg     <= pad_byte_reg;
            endcase
        end
    end

    // Saturate kernel dimensions
    assign kh_eff = (kernel_shape_reg[7:0] > 8'(MAX_KERNEL)) ? KW_W'(MAX_KERNEL)
                                                              : kernel_shape_reg[KW_W-1:0];
    assign kw_eff = (kernel_shape_reg[15:8] > 8'(MAX_KERNEL)) ? KW_W'(MAX_KERNEL)
                                                               : kernel_shape_reg[KW_W+7:8];

    assign dv_s = $signed({{(CW-8){1'b0}}, window_step_reg[23:16]});
    assign dh_s = $signed({{(CW-8){1'b0}}, window_step_reg[31:24]});

    // Select shared multiplier operands; only the low 32 product bits matter
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            im2col_pkg::MUL_V:
            begin
                mul_a = {16'd0, req_reg.output_row};
                mul_b = {24'd0, window_step_reg[7:0]};
            end
            im2col_pkg::MUL_H:
            begin
                mul_a = {16'd0, req_reg.output_col};
                mul_b = {24'd0, window_step_reg[15:8]};
            end
            im2col_pkg::MUL_ROW_ADDR:
            begin
                mul_a = {{(32-CW){v_reg[CW-1]}}, v_reg};
                mul_b = {8'd0, row_bytes_reg};
            end
            im2col_pkg::MUL_COL_ADDR:
            begin
                mul_a = {{(32-CW){h0_reg[CW-1]}}, h0_reg};
                mul_b = {16'd0, pixel_bytes_reg};
            end
            im2col_pkg::MUL_ROW_STEP:
            begin
                mul_a = {24'd0, window_step_reg[23:16]};
                mul_b = {8'd0, row_bytes_reg};
            end
            im2col_pkg::MUL_COL_STEP:
            begin
                mul_a = {24'd0, window_step_reg[31:24]};
                mul_b = {16'd0, pixel_bytes_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Classify the current tap against the image bounds
    assign v_out   = v_reg[CW-1] || (v_reg[CW-2:0] >= (CW-1)'(input_extent_reg[15:0]));
    assign h_out   = h_reg[CW-1] || (h_reg[CW-2:0] >= (CW-1)'(input_extent_reg[31:16]));
    assign outside = v_out || h_out;
    assign row_end = (j_reg == KW_W'(kw_eff - 1'b1));

    // Latch the request, run setup products, walk the taps
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg     <= request;
            wr_addr_reg <= request.patch_base;
            i_reg       <= '0;
            j_reg       <= '0;
        end
        else if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                im2col_pkg::MUL_V:
                begin
                    v_reg <= $signed(mul_p[CW-1:0] - {{(CW-8){1'b0}}, pad_offsets_reg[7:0]});
                end
                im2col_pkg::MUL_H:
                begin
                    h_reg  <= $signed(mul_p[CW-1:0] - {{(CW-8){1'b0}}, pad_offsets_reg[15:8]});
                    h0_reg <= $signed(mul_p[CW-1:0] - {{(CW-8){1'b0}}, pad_offsets_reg[15:8]});
                end
                im2col_pkg::MUL_ROW_ADDR:
                begin
                    row_addr_reg <= req_reg.source_base + {16'd0, req_reg.channel_offset} + mul_p;
                end
                im2col_pkg::MUL_COL_ADDR:
                begin
                    col_addr_reg <= mul_p;
                    col_base_reg <= mul_p;
                end
                im2col_pkg::MUL_ROW_STEP:
                begin
                    row_step_reg <= mul_p;
                end
                im2col_pkg::MUL_COL_STEP:
                begin
                    col_step_reg <= mul_p;
                end
                default:
                begin
                    col_step_reg <= col_step_reg;
                end
            endcase
        end
        else if (cmd.tap)
        begin
            wr_addr_reg <= wr_addr_reg + {16'd0, copy_bytes_reg};
            if (row_end)
            begin
                j_reg        <= '0;
                h_reg        <= h0_reg;
                col_addr_reg <= col_base_reg;
                i_reg        <= i_reg + 1'b1;
                v_reg        <= v_reg + dv_s;
                row_addr_reg <= row_addr_reg + row_step_reg;
            end
            else
            begin
                j_reg        <= j_reg + 1'b1;
                h_reg        <= h_reg + dh_s;
                col_addr_reg <= col_addr_reg + col_step_reg;
            end
        end
    end

    // Build the command for this cycle
    always_comb
    begin
        result_next               = '0;
        result_next.write_address = wr_addr_reg;
        if (cmd.tail)
        begin
            result_next.command_kind = im2col_pkg::KIND_TAIL;
            result_next.byte_count   = im2col_pkg::TAIL_BYTES;
            result_next.last         = 1'b1;
        end
        else
        begin
            result_next.byte_count = copy_bytes_reg;
            if (outside)
            begin
                result_next.command_kind = im2col_pkg::KIND_FILL;
                result_next.fill_value   = $signed(pad_byte_reg);
            end
            else
            begin
                result_next.command_kind = im2col_pkg::KIND_COPY;
                result_next.read_address = row_addr_reg + col_addr_reg;
            end
        end
    end

    // Register the command payload
    always_ff @(posedge clk)
    begin
        if (cmd.tap || cmd.tail)
        begin
            result_reg <= result_next;
        end
    end

    // Register the strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.tap || cmd.tail;
        end
    end

    assign status.kernel_empty = (kh_eff == '0) || (kw_eff == '0);
    assign status.row_end      = row_end;
    assign status.last_row     = (i_reg == KW_W'(kh_eff - 1'b1));
    assign result              = result_reg;
    assign result_strobe       = strobe_reg;

endmodule

>>> hdl/im2col_padded_patch_gather_top.sv
// Top level of the im2col patch gather: ties the controller to the datapath.
// Depends on im2col_pkg, im2col_ctrl and im2col_dp.
//
//   channel   ports                                  transfer
//   config    cfg_we, cfg_index, cfg_data            cfg_we high at a rising edge
//   request   start, busy, request                   start high and busy low
//   result    result_strobe, result                  result_strobe high at a rising edge
//
// After a request is taken, setup steps compute the start coordinates, base addresses and
// steps on one shared multiplier, then one command leaves per kernel tap and one for the
// zero tail; each command is registered and appears in the cycle after it is formed. busy
// drops in the cycle the tail command is shown, so a new request can be taken then. Reset
// is asynchronous, active low, and restores the register defaults.
// The receiver takes every result as it comes; nothing stalls.
module im2col_padded_patch_gather_top
#(
    parameter int MAX_KERNEL = im2col_pkg::MAX_KERNEL_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [31:0]             cfg_data,
    input  logic                    start,
    input  im2col_pkg::request_t    request,
    output logic                    busy,
    output im2col_pkg::result_t     result,
    output logic                    result_strobe
);

    im2col_pkg::ctrl_cmd_t  cmd;
    im2col_pkg::dp_status_t status;

    // Sequence the work
    im2col_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Compute addresses and commands
    im2col_dp
    #(
        .MAX_KERNEL (MAX_KERNEL)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .request       (request),
        .cmd           (cmd),
        .status        (status),
        .result        (result),
        .result_strobe (result_strobe)
    );

    // An accepted request keeps the block busy through its setup
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request transfer");

    // Busy only rises on a request transfer
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // The tail command ends the run
    a_tail_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |-> !busy)
        else $error("still busy when tail command shown");

    // Tap commands appear only inside a run
    a_tap_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last) |-> busy)
        else $error("tap command outside a run");

endmodule
